FILE: src/bvam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvam_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WIN_W          = 7;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int M_TDATA_W      = 40;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int MIN_WINDOW     = 3;
    localparam int TRIM_COUNT     = 2;

    localparam logic [SAMPLE_W-1:0] SATURATED = 16'hFFFF;

    localparam logic [SAMPLE_W-1:0] OVER_RESET   = 16'd65534;
    localparam logic [SAMPLE_W-1:0] UNDER_RESET  = 16'd0;
    localparam logic [WIN_W-1:0]    WINDOW_RESET = 7'd64;
    localparam logic                MODE_RESET   = 1'b0;
    localparam logic [SAMPLE_W-1:0] MID_RESET    = 16'd32767;

    localparam logic [CFG_IDX_W-1:0] REG_OVER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    localparam logic MODE_DIRECT   = 1'b0;
    localparam logic MODE_FILTERED = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_OVER  = 2'd1,
        FAULT_UNDER = 2'd2
    } fault_t;

endpackage

`default_nettype wire

FILE: src/bvam_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module bvam_ring #(
    parameter int MAX_WINDOW = 64,
    parameter int IDX_W      = 6
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire logic [bvam_pkg::SAMPLE_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]              rd_addr,
    output logic      [bvam_pkg::SAMPLE_W-1:0] rd_data,
    input  wire logic                          clr,
    input  wire logic [bvam_pkg::SAMPLE_W-1:0] clr_value
);
    import bvam_pkg::*;

    logic [SAMPLE_W-1:0]   mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] valid_reg;
    logic [SAMPLE_W-1:0]   clr_val_reg;
    logic [SAMPLE_W-1:0]   rd_raw_reg;
    logic                  rd_valid_reg;

    // Entry storage and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    // Entries never written since the last clear read as the fill value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            clr_val_reg  <= MID_RESET;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (clr) begin
                valid_reg   <= '0;
                clr_val_reg <= clr_value;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : clr_val_reg;

endmodule

`default_nettype wire

FILE: src/bvam_div.sv
`timescale 1ns / 1ps
`default_nettype none

module bvam_div #(
    parameter int SUM_W = 22,
    parameter int LEN_W = 7
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [LEN_W-1:0] divisor,
    output logic                  done,
    output logic      [SUM_W-1:0] quotient
);
    import bvam_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [LEN_W:0]   shifted;
    logic             fits;

    // One restoring step per cycle, quotient bits shift in from the right
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? LEN_W'(shifted - {1'b0, dvs_reg}) : shifted[LEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: src/bus_voltage_average_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// A clear or saturated sample goes from accept through ST_OUT to the result; a mid-burst
// sample passes ST_BURST, then ST_OUT. A ring push runs ST_PUSH, the L-entry sweep of the
// ring memory in ST_SWEEP, then SUM_W steps of the shared divider in ST_ADIV; a burst that
// completes adds SUM_W divider steps in ST_TDIV first. One item in flight; the next item is
// taken once a result is staged. Reset (synchronous, aresetn low): registers to defaults,
// every ring entry reads as the midpoint 32767 through per-entry valid bits; no clearing pass.
module bus_voltage_average_monitor #(
    parameter int MAX_WINDOW = bvam_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bvam_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
    input  wire logic                            s_tuser,   // [0] req_type
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [bvam_pkg::M_TDATA_W-1:0]  m_tdata,   // [15:0] average, [31:16] latest,
                                                            // [33:32] fault, [39:34] zero
    output logic                                 m_tuser,   // [0] updated
    // configuration writes
    input  wire logic                            cfg_we,
    input  wire logic [bvam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bvam_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bvam_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BURST,
        ST_TDIV,
        ST_PUSH,
        ST_SWEEP,
        ST_ADIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [SAMPLE_W-1:0] over_reg;
    logic [SAMPLE_W-1:0] under_reg;
    logic [WIN_W-1:0]    window_reg;
    logic                mode_reg;

    // block state
    logic [IDX_W-1:0]    write_pos_reg;
    logic [SAMPLE_W-1:0] average_reg;
    logic [SAMPLE_W-1:0] latest_reg;
    logic [LEN_W-1:0]    burst_count_reg;
    logic [SUM_W-1:0]    burst_sum_reg;
    logic [SAMPLE_W-1:0] burst_min_reg;
    logic [SAMPLE_W-1:0] burst_max_reg;

    // working registers
    logic [SAMPLE_W-1:0] push_val_reg;
    logic [LEN_W-1:0]    sweep_cnt_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic                updated_reg;

    // result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [LEN_W-1:0]    eff_len;
    logic [SAMPLE_W:0]   mid_wide;
    logic [SAMPLE_W-1:0] midpoint;
    logic                s_fire;
    logic                out_free;
    logic                out_load;
    fault_t              fault;

    logic [SUM_W-1:0]    burst_base;
    logic [SUM_W-1:0]    trimmed;
    logic [LEN_W:0]      pos_inc;

    logic                ring_clr;
    logic                ring_wr;
    logic [SAMPLE_W-1:0] ring_rd_data;

    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    logic [LEN_W-1:0]    div_divisor;
    logic                div_done;
    logic [SUM_W-1:0]    div_quotient;

    // Clamp the configured window into the ring's range
    always_comb begin
        if (window_reg < WIN_W'(MIN_WINDOW)) begin
            eff_len = LEN_W'(MIN_WINDOW);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(window_reg);
        end
    end

    assign mid_wide = {1'b0, over_reg} + {1'b0, under_reg};
    assign midpoint = mid_wide[SAMPLE_W:1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    // Fault code follows the current average and thresholds
    always_comb begin
        if (average_reg > over_reg) begin
            fault = FAULT_OVER;
        end else if (average_reg < under_reg) begin
            fault = FAULT_UNDER;
        end else begin
            fault = FAULT_NONE;
        end
    end

    // Trim the largest and smallest sample off a full burst
    assign trimmed = burst_sum_reg - SUM_W'(burst_max_reg) - SUM_W'(burst_min_reg);
    assign burst_base = (burst_count_reg == '0) ? '0 : burst_sum_reg;
    assign pos_inc = (LEN_W + 1)'(write_pos_reg) + 1'b1;

    // Ring clear and write strobes
    assign ring_clr = s_fire && (s_tuser == REQ_CLEAR);
    assign ring_wr  = (state_reg == ST_PUSH);

    // Shared divider: trimmed burst sum by L-2, or ring sum by L
    always_comb begin
        div_start    = 1'b0;
        div_dividend = acc_reg;
        div_divisor  = eff_len;
        case (state_reg)
            ST_BURST: begin
                div_start    = (burst_count_reg >= eff_len);
                div_dividend = trimmed;
                div_divisor  = eff_len - LEN_W'(TRIM_COUNT);
            end
            ST_SWEEP: begin
                div_start = (sweep_cnt_reg == eff_len);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            over_reg   <= OVER_RESET;
            under_reg  <= UNDER_RESET;
            window_reg <= WINDOW_RESET;
            mode_reg   <= MODE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_OVER:   over_reg   <= cfg_data;
                REG_UNDER:  under_reg  <= cfg_data;
                REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Sequencer: accept, gather burst, divide, write ring, sweep, divide, stage result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            write_pos_reg   <= '0;
            average_reg     <= MID_RESET;
            latest_reg      <= MID_RESET;
            burst_count_reg <= '0;
            burst_sum_reg   <= '0;
            burst_min_reg   <= '0;
            burst_max_reg   <= '0;
            updated_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        updated_reg <= 1'b0;
                        state_reg   <= ST_OUT;
                        if (s_tuser == REQ_CLEAR) begin
                            // refill with midpoint, drop any partial burst
                            write_pos_reg   <= '0;
                            average_reg     <= midpoint;
                            latest_reg      <= midpoint;
                            burst_count_reg <= '0;
                            burst_sum_reg   <= '0;
                            burst_min_reg   <= '0;
                            burst_max_reg   <= '0;
                        end else if (s_tdata != SATURATED) begin
                            if (mode_reg == MODE_DIRECT) begin
                                push_val_reg <= s_tdata;
                                state_reg    <= ST_PUSH;
                            end else begin
                                burst_count_reg <= burst_count_reg + 1'b1;
                                burst_sum_reg   <= burst_base + SUM_W'(s_tdata);
                                if (burst_count_reg == '0) begin
                                    burst_min_reg <= s_tdata;
                                    burst_max_reg <= s_tdata;
                                end else begin
                                    if (s_tdata < burst_min_reg) burst_min_reg <= s_tdata;
                                    if (s_tdata > burst_max_reg) burst_max_reg <= s_tdata;
                                end
                                state_reg <= ST_BURST;
                            end
                        end
                    end
                end
                ST_BURST: begin
                    if (div_start) begin
                        burst_count_reg <= '0;
                        burst_sum_reg   <= '0;
                        burst_min_reg   <= '0;
                        burst_max_reg   <= '0;
                        state_reg       <= ST_TDIV;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_TDIV: begin
                    if (div_done) begin
                        push_val_reg <= div_quotient[SAMPLE_W-1:0];
                        state_reg    <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    // entry is written this cycle; advance or wrap the write position
                    latest_reg    <= push_val_reg;
                    write_pos_reg <= (pos_inc < (LEN_W + 1)'(eff_len))
                                     ? pos_inc[IDX_W-1:0] : '0;
                    sweep_cnt_reg <= '0;
                    acc_reg       <= '0;
                    state_reg     <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    // read entry cnt, add entry cnt-1 returned by the memory
                    if (sweep_cnt_reg != '0) begin
                        acc_reg <= acc_reg + SUM_W'(ring_rd_data);
                    end
                    if (div_start) begin
                        state_reg <= ST_ADIV;
                    end else begin
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    end
                end
                ST_ADIV: begin
                    if (div_done) begin
                        average_reg <= div_quotient[SAMPLE_W-1:0];
                        updated_reg <= 1'b1;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the result register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'b0, fault, latest_reg, average_reg};
                        m_tuser_reg  <= updated_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Sweep accumulation sees the divider's start in the same cycle as the last add,
    // so the dividend must include that final entry
    logic [SUM_W-1:0] acc_final;
    assign acc_final = acc_reg + SUM_W'(ring_rd_data);

    bvam_ring #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (ring_wr),
        .wr_addr   (write_pos_reg),
        .wr_data   (push_val_reg),
        .rd_addr   (sweep_cnt_reg[IDX_W-1:0]),
        .rd_data   (ring_rd_data),
        .clr       (ring_clr),
        .clr_value (midpoint)
    );

    bvam_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ((state_reg == ST_SWEEP) ? acc_final : div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
